// File: rtl/core/ttt_pkg.sv
package ttt_pkg;

  // Table sizes.
  localparam int unsigned PERIODIC_SLOTS = 10;
  localparam int unsigned ONESHOT_SLOTS  = 10;

  // Slot index widths, and counter widths that can also hold the slot count itself.
  localparam int unsigned PIDX_W = (PERIODIC_SLOTS > 1) ? $clog2(PERIODIC_SLOTS) : 1;
  localparam int unsigned PCNT_W = $clog2(PERIODIC_SLOTS + 1);
  localparam int unsigned OIDX_W = (ONESHOT_SLOTS > 1) ? $clog2(ONESHOT_SLOTS) : 1;
  localparam int unsigned OCNT_W = $clog2(ONESHOT_SLOTS + 1);

  // Field widths.
  localparam int unsigned OP_W   = 2;
  localparam int unsigned TIME_W = 32;
  localparam int unsigned KIND_W = 3;
  localparam int unsigned SLOT_W = 4;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_TICK         = 2'd0;
  localparam logic [OP_W-1:0] OP_ADD_PERIODIC = 2'd1;
  localparam logic [OP_W-1:0] OP_ADD_ONESHOT  = 2'd2;

  // Result kinds.
  localparam logic [KIND_W-1:0] RK_PERIODIC_FIRE = 3'd0;
  localparam logic [KIND_W-1:0] RK_ONESHOT_FIRE  = 3'd1;
  localparam logic [KIND_W-1:0] RK_PERIODIC_ACK  = 3'd2;
  localparam logic [KIND_W-1:0] RK_ONESHOT_ACK   = 3'd3;
  localparam logic [KIND_W-1:0] RK_TICK_DONE     = 3'd4;

  // One entry of the periodic slot memory.
  typedef struct packed {
    logic [TIME_W-1:0] interval;
    logic [TIME_W-1:0] count;
  } periodic_entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_P_RD,
    ST_P_WB,
    ST_O_RD,
    ST_O_WB,
    ST_DONE
  } state_e;

endpackage

// File: rtl/core/tick_task_timer_table.sv
// Tick timer table with periodic and one-shot slots. Each input item is a tick, an add of a
// periodic slot or an add of a one-shot slot. An add answers with a single acknowledge item
// in the cycle after it is accepted. A tick walks the periodic slots in use and then every
// one-shot slot, and emits one item for each slot that fires followed by a tick-done item
// that carries last. The slot state lives in two single-port synchronous memories with
// registered read data. The tick walk takes a read and a write-back state for each periodic
// slot in use, a read state for every one-shot slot and a write-back state for each active
// one, and then loads the tick-done item and returns to idle. A fire or tick-done item
// waits while the output register is full and not being emptied.
// Only one item is in the block at a time: a new item is accepted when the block is idle
// and the output register is free or being emptied in that cycle. The stores need no
// clearing pass after reset, since only slots that have been written are ever read.
module tick_task_timer_table (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [ttt_pkg::OP_W-1:0]      operation_i,
  input  logic [ttt_pkg::TIME_W-1:0]    time_value_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [ttt_pkg::KIND_W-1:0]    result_kind_o,
  output logic [ttt_pkg::SLOT_W-1:0]    slot_o,
  output logic                          accepted_o,
  output logic [ttt_pkg::TIME_W-1:0]    time_count_o,
  output logic                          last_o
);

  localparam int unsigned PIDX_W = ttt_pkg::PIDX_W;
  localparam int unsigned PCNT_W = ttt_pkg::PCNT_W;
  localparam int unsigned OIDX_W = ttt_pkg::OIDX_W;
  localparam int unsigned OCNT_W = ttt_pkg::OCNT_W;
  localparam int unsigned TIME_W = ttt_pkg::TIME_W;

  // Sequencer state.
  ttt_pkg::state_e                 state_q, state_d;
  logic [PCNT_W-1:0]               pidx_q, pidx_d;
  logic [OCNT_W-1:0]               oidx_q, oidx_d;
  logic [PCNT_W-1:0]               used_q, used_d;
  logic [ttt_pkg::ONESHOT_SLOTS-1:0] active_q, active_d;
  logic [TIME_W-1:0]               tick_q, tick_d;

  // Slot memories. Each access is a read in one state followed by the write-back in the
  // next, and the walk moves to another slot only after the write-back, so accesses to
  // one entry never overlap and no forwarding is needed.
  ttt_pkg::periodic_entry_t        pmem [ttt_pkg::PERIODIC_SLOTS];
  ttt_pkg::periodic_entry_t        prd_data_q;
  ttt_pkg::periodic_entry_t        pwr_data;
  logic                            prd_en, pwr_en;
  logic [PIDX_W-1:0]               p_addr;

  logic [TIME_W-1:0]               omem [ttt_pkg::ONESHOT_SLOTS];
  logic [TIME_W-1:0]               ord_data_q;
  logic [TIME_W-1:0]               owr_data;
  logic                            ord_en, owr_en;
  logic [OIDX_W-1:0]               o_addr;

  // Output register.
  logic                            out_valid_q;
  logic [ttt_pkg::KIND_W-1:0]      kind_q;
  logic [ttt_pkg::SLOT_W-1:0]      slot_q;
  logic                            acc_q;
  logic [TIME_W-1:0]               time_q;
  logic                            last_q;

  logic                            out_free;
  logic                            emit;
  logic [ttt_pkg::KIND_W-1:0]      emit_kind;
  logic [ttt_pkg::SLOT_W-1:0]      emit_slot;
  logic                            emit_acc;
  logic                            emit_last;

  // Lowest free one-shot slot.
  logic                            free_found;
  logic [OIDX_W-1:0]               free_idx;

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = ttt_pkg::ONESHOT_SLOTS - 1; i >= 0; i--) begin
      if (!active_q[i]) begin
        free_found = 1'b1;
        free_idx   = OIDX_W'(i);
      end
    end
  end

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d   = state_q;
    pidx_d    = pidx_q;
    oidx_d    = oidx_q;
    used_d    = used_q;
    active_d  = active_q;
    tick_d    = tick_q;
    in_ready_o = 1'b0;
    prd_en    = 1'b0;
    pwr_en    = 1'b0;
    p_addr    = pidx_q[PIDX_W-1:0];
    pwr_data  = prd_data_q;
    ord_en    = 1'b0;
    owr_en    = 1'b0;
    o_addr    = oidx_q[OIDX_W-1:0];
    owr_data  = ord_data_q;
    emit      = 1'b0;
    emit_kind = ttt_pkg::RK_TICK_DONE;
    emit_slot = '0;
    emit_acc  = 1'b0;
    emit_last = 1'b0;

    unique case (state_q)
      ttt_pkg::ST_IDLE: begin
        in_ready_o = out_free;
        if (in_valid_i && out_free) begin
          unique case (operation_i)
            ttt_pkg::OP_TICK: begin
              tick_d  = tick_q + TIME_W'(1);
              pidx_d  = '0;
              state_d = ttt_pkg::ST_P_RD;
            end
            ttt_pkg::OP_ADD_PERIODIC: begin
              emit      = 1'b1;
              emit_kind = ttt_pkg::RK_PERIODIC_ACK;
              emit_last = 1'b1;
              if (used_q < PCNT_W'(ttt_pkg::PERIODIC_SLOTS)) begin
                pwr_en            = 1'b1;
                p_addr            = used_q[PIDX_W-1:0];
                pwr_data.interval = time_value_i;
                pwr_data.count    = '0;
                used_d            = used_q + PCNT_W'(1);
                emit_slot         = ttt_pkg::SLOT_W'(used_q);
                emit_acc          = 1'b1;
              end
            end
            ttt_pkg::OP_ADD_ONESHOT: begin
              emit      = 1'b1;
              emit_kind = ttt_pkg::RK_ONESHOT_ACK;
              emit_last = 1'b1;
              if (free_found) begin
                owr_en             = 1'b1;
                o_addr             = free_idx;
                owr_data           = time_value_i;
                active_d[free_idx] = 1'b1;
                emit_slot          = ttt_pkg::SLOT_W'(free_idx);
                emit_acc           = 1'b1;
              end
            end
            default: ;  // unused code: no result, no change
          endcase
        end
      end

      ttt_pkg::ST_P_RD: begin
        if (pidx_q < used_q) begin
          prd_en  = 1'b1;
          state_d = ttt_pkg::ST_P_WB;
        end else begin
          oidx_d  = '0;
          state_d = ttt_pkg::ST_O_RD;
        end
      end

      ttt_pkg::ST_P_WB: begin
        if (prd_data_q.count >= prd_data_q.interval) begin
          emit      = 1'b1;
          emit_kind = ttt_pkg::RK_PERIODIC_FIRE;
          emit_slot = ttt_pkg::SLOT_W'(pidx_q);
          if (out_free) begin
            pwr_en         = 1'b1;
            pwr_data.count = '0;
            pidx_d         = pidx_q + PCNT_W'(1);
            state_d        = ttt_pkg::ST_P_RD;
          end
        end else begin
          pwr_en         = 1'b1;
          pwr_data.count = prd_data_q.count + TIME_W'(1);
          pidx_d         = pidx_q + PCNT_W'(1);
          state_d        = ttt_pkg::ST_P_RD;
        end
      end

      ttt_pkg::ST_O_RD: begin
        if (oidx_q == OCNT_W'(ttt_pkg::ONESHOT_SLOTS)) begin
          state_d = ttt_pkg::ST_DONE;
        end else if (active_q[oidx_q[OIDX_W-1:0]]) begin
          ord_en  = 1'b1;
          state_d = ttt_pkg::ST_O_WB;
        end else begin
          oidx_d = oidx_q + OCNT_W'(1);
        end
      end

      ttt_pkg::ST_O_WB: begin
        if (ord_data_q == '0) begin
          emit      = 1'b1;
          emit_kind = ttt_pkg::RK_ONESHOT_FIRE;
          emit_slot = ttt_pkg::SLOT_W'(oidx_q);
          if (out_free) begin
            active_d[oidx_q[OIDX_W-1:0]] = 1'b0;
            oidx_d  = oidx_q + OCNT_W'(1);
            state_d = ttt_pkg::ST_O_RD;
          end
        end else begin
          owr_en   = 1'b1;
          owr_data = ord_data_q - TIME_W'(1);
          oidx_d   = oidx_q + OCNT_W'(1);
          state_d  = ttt_pkg::ST_O_RD;
        end
      end

      ttt_pkg::ST_DONE: begin
        emit      = 1'b1;
        emit_kind = ttt_pkg::RK_TICK_DONE;
        emit_last = 1'b1;
        if (out_free) begin
          state_d = ttt_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = ttt_pkg::ST_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ttt_pkg::ST_IDLE;
      pidx_q   <= '0;
      oidx_q   <= '0;
      used_q   <= '0;
      active_q <= '0;
      tick_q   <= '0;
    end else begin
      state_q  <= state_d;
      pidx_q   <= pidx_d;
      oidx_q   <= oidx_d;
      used_q   <= used_d;
      active_q <= active_d;
      tick_q   <= tick_d;
    end
  end

  // Slot memories, read data registered.
  always_ff @(posedge clk_i) begin
    if (pwr_en) begin
      pmem[p_addr] <= pwr_data;
    end
    if (prd_en) begin
      prd_data_q <= pmem[p_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (owr_en) begin
      omem[o_addr] <= owr_data;
    end
    if (ord_en) begin
      ord_data_q <= omem[o_addr];
    end
  end

  // Output register. The tick count is already advanced when a tick's results are loaded.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit && out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit && out_free) begin
      kind_q <= emit_kind;
      slot_q <= emit_slot;
      acc_q  <= emit_acc;
      time_q <= tick_q;
      last_q <= emit_last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign result_kind_o = kind_q;
  assign slot_o        = slot_q;
  assign accepted_o    = acc_q;
  assign time_count_o  = time_q;
  assign last_o        = last_q;

endmodule

// File: rtl/core/ttt_checker.sv
module ttt_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input logic [ttt_pkg::OP_W-1:0]      operation_i,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic [ttt_pkg::KIND_W-1:0]    result_kind_o,
  input logic [ttt_pkg::SLOT_W-1:0]    slot_o,
  input logic                          accepted_o,
  input logic [ttt_pkg::TIME_W-1:0]    time_count_o,
  input logic                          last_o
);

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(result_kind_o) &&
      $stable(slot_o) && $stable(accepted_o) && $stable(time_count_o) && $stable(last_o))
    else $error("result changed while stalled");

  // A tick keeps the block busy for at least the following cycle.
  a_tick_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && operation_i == ttt_pkg::OP_TICK |=> !in_ready_o)
    else $error("new item taken during a tick walk");

  // Fire results are never final and never carry an acknowledge.
  a_fire_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (result_kind_o == ttt_pkg::RK_PERIODIC_FIRE ||
      result_kind_o == ttt_pkg::RK_ONESHOT_FIRE) |-> !last_o && !accepted_o)
    else $error("malformed fire result");

  // Tick done and refused adds report slot zero and close the item.
  a_done_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (result_kind_o == ttt_pkg::RK_TICK_DONE ||
      ((result_kind_o == ttt_pkg::RK_PERIODIC_ACK ||
        result_kind_o == ttt_pkg::RK_ONESHOT_ACK) && !accepted_o))
      |-> last_o && slot_o == '0)
    else $error("malformed closing result");

endmodule

bind tick_task_timer_table ttt_checker u_ttt_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .operation_i   (operation_i),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .result_kind_o (result_kind_o),
  .slot_o        (slot_o),
  .accepted_o    (accepted_o),
  .time_count_o  (time_count_o),
  .last_o        (last_o)
);
